// File: sv/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/mmpw_pkg.sv
// package: constants and command/status types of the walk count core
`default_nettype none

package mmpw_pkg;

   localparam int DEF_NODES    = 8;
   localparam int DEF_EXP_BITS = 30;
   localparam int ROW_REGS     = 8;
   localparam int ROW_IW       = 3;
   localparam int EXP_W        = 30;
   localparam int NODE_W       = 3;
   localparam int CNT_W        = 30;
   localparam int ADJ_W        = 8;
   localparam int CSR_IDX_W    = 8;

   localparam logic [63:0] MODULUS_64 = 64'd1000000007;
   localparam logic [29:0] MODULUS    = 30'd1000000007;
   localparam logic [31:0] MODULUS_X2 = 32'd2000000014;
   // barrett constant floor(2^60 / p)
   localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / MODULUS_64);

   localparam logic [ADJ_W-1:0] ADJ_RESET [ROW_REGS] =
      '{8'd6, 8'd13, 8'd27, 8'd54, 8'd172, 8'd88, 8'd160, 8'd80};

   typedef struct packed {
      logic load;
      logic start_mul;
      logic use_adj;
      logic start_rd;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic ident;
      logic mul_done;
      logic rd_done;
   } status_type;

endpackage

`default_nettype wire

// File: sv/mmpw_datapath.sv
// datapath: matrix memory, modular multiply-accumulate pipeline, adjacency registers
`default_nettype none

`include "assert_macros.svh"

module mmpw_datapath
   import mmpw_pkg::*;
#(
   parameter int NODES = DEF_NODES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADJ_W-1:0]     csr_wdata,
   input  wire logic [NODE_W-1:0]    req_from_node,
   input  wire logic [NODE_W-1:0]    req_to_node,
   output logic [CNT_W-1:0]          rsp_walk_count,
   input  wire cmd_type              cmd,
   output status_type                status
);

   localparam int IW = $clog2(NODES);
   localparam int AW = $clog2(NODES * NODES);
   localparam int MW = AW + 1;
   localparam logic [IW-1:0] LAST = IW'(NODES - 1);

   typedef struct packed {
      logic          valid;
      logic          first;
      logic          last;
      logic          fin;
      logic [AW-1:0] dest;
   } tag_type;

   logic [ADJ_W-1:0] adj_ff [ROW_REGS];
   logic [CNT_W-1:0] mem [1 << MW];

   logic [IW-1:0]     i_ff, j_ff, k_ff;
   logic              active_ff, bank_ff, ident_ff, use_adj_ff;
   logic [NODE_W-1:0] from_ff, to_ff;
   tag_type           tag0_ff, taga_ff, tagb_ff, tagc_ff, tag0_in;
   logic              idl_ff, idr_ff, adjb_ff;
   logic [CNT_W-1:0]  lhs_q_ff, rhs_q_ff;
   logic [59:0]       prod_ff;
   logic [61:0]       q2_ff;
   logic [31:0]       plo_ff, r_ff;
   logic [CNT_W-1:0]  acc_ff, rd_val_ff, rsp_ff;
   logic              mul_done_ff, rd_pend_ff, rd_done_ff;

   logic [AW-1:0]    rd_addr, lhs_cell, rhs_cell;
   logic [MW-1:0]    lhs_addr, rhs_addr, wr_addr;
   logic [CNT_W-1:0] a_op, b_op, acc_in;
   logic [31:0]      t_mul, r1;
   logic [30:0]      sum;
   logic             adj_bit, node_ok;
   int               kx, jx;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         adj_ff <= ADJ_RESET;
      end else if (csr_valid && csr_ready && int'(csr_index) < ROW_REGS &&
                   int'(csr_index) < NODES) begin
         adj_ff[csr_index[ROW_IW-1:0]] <= csr_wdata;
      end
   end

   always_comb begin
      kx       = int'(k_ff);
      jx       = int'(j_ff);
      adj_bit  = 1'b0;
      if (kx < ROW_REGS && jx < ROW_REGS) begin
         adj_bit = adj_ff[ROW_IW'(kx)][ROW_IW'(jx)];
      end
      rd_addr  = AW'(int'(from_ff) * NODES + int'(to_ff));
      lhs_cell = AW'(int'(i_ff) * NODES + int'(k_ff));
      rhs_cell = AW'(int'(k_ff) * NODES + int'(j_ff));
      lhs_addr = {bank_ff, active_ff ? lhs_cell : rd_addr};
      rhs_addr = {bank_ff, rhs_cell};
      wr_addr  = {~bank_ff, tagc_ff.dest};
      node_ok  = int'(from_ff) < NODES && int'(to_ff) < NODES;
      tag0_in.valid = active_ff;
      tag0_in.first = (k_ff == '0);
      tag0_in.last  = (k_ff == LAST);
      tag0_in.fin   = (k_ff == LAST) && (j_ff == LAST) && (i_ff == LAST);
      tag0_in.dest  = AW'(int'(i_ff) * NODES + int'(j_ff));
   end

   // identity matrix is substituted until the first product is written
   always_comb begin
      a_op = ident_ff ? CNT_W'(idl_ff) : lhs_q_ff;
      if (use_adj_ff) begin
         b_op = CNT_W'(adjb_ff);
      end else begin
         b_op = ident_ff ? CNT_W'(idr_ff) : rhs_q_ff;
      end
      t_mul = 32'(q2_ff[61:31]) * 32'(MODULUS);
      // barrett remainder is below 3p
      if (r_ff >= MODULUS_X2) begin
         r1 = r_ff - MODULUS_X2;
      end else if (r_ff >= 32'(MODULUS)) begin
         r1 = r_ff - 32'(MODULUS);
      end else begin
         r1 = r_ff;
      end
      sum = (tagc_ff.first ? 31'd0 : 31'(acc_ff)) + 31'(r1);
      acc_in = (sum >= 31'(MODULUS)) ? CNT_W'(sum - 31'(MODULUS)) : CNT_W'(sum);
   end

   always_ff @(posedge clock) begin
      if (tagc_ff.valid && tagc_ff.last) begin
         mem[wr_addr] <= acc_in;
      end
      lhs_q_ff <= mem[lhs_addr];
      rhs_q_ff <= mem[rhs_addr];
   end

   always_ff @(posedge clock) begin
      idl_ff  <= (i_ff == k_ff);
      idr_ff  <= (k_ff == j_ff);
      adjb_ff <= adj_bit;
      prod_ff <= a_op * b_op;
      q2_ff   <= 62'(prod_ff[59:29]) * 62'(BARRETT_MU);
      plo_ff  <= prod_ff[31:0];
      r_ff    <= plo_ff - t_mul;
      if (tagc_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (rd_pend_ff) begin
         if (!node_ok) begin
            rd_val_ff <= '0;
         end else if (ident_ff) begin
            rd_val_ff <= CNT_W'(from_ff == to_ff);
         end else begin
            rd_val_ff <= lhs_q_ff;
         end
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rd_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff        <= '0;
         j_ff        <= '0;
         k_ff        <= '0;
         active_ff   <= 1'b0;
         bank_ff     <= 1'b0;
         ident_ff    <= 1'b1;
         use_adj_ff  <= 1'b0;
         from_ff     <= '0;
         to_ff       <= '0;
         tag0_ff     <= '0;
         taga_ff     <= '0;
         tagb_ff     <= '0;
         tagc_ff     <= '0;
         mul_done_ff <= 1'b0;
         rd_pend_ff  <= 1'b0;
         rd_done_ff  <= 1'b0;
      end else begin
         tag0_ff     <= tag0_in;
         taga_ff     <= tag0_ff;
         tagb_ff     <= taga_ff;
         tagc_ff     <= tagb_ff;
         rd_pend_ff  <= cmd.start_rd;
         rd_done_ff  <= rd_pend_ff;
         mul_done_ff <= tagc_ff.valid && tagc_ff.fin;
         if (tagc_ff.valid && tagc_ff.fin) begin
            bank_ff  <= ~bank_ff;
            ident_ff <= 1'b0;
         end
         if (cmd.load) begin
            from_ff  <= req_from_node;
            to_ff    <= req_to_node;
            ident_ff <= 1'b1;
         end
         if (cmd.start_mul) begin
            active_ff  <= 1'b1;
            use_adj_ff <= cmd.use_adj;
            i_ff       <= '0;
            j_ff       <= '0;
            k_ff       <= '0;
         end else if (active_ff) begin
            if (k_ff == LAST) begin
               k_ff <= '0;
               if (j_ff == LAST) begin
                  j_ff <= '0;
                  if (i_ff == LAST) begin
                     active_ff <= 1'b0;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                  end
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end else begin
               k_ff <= k_ff + 1'b1;
            end
         end
      end
   end

   assign rsp_walk_count  = rsp_ff;
   assign status.ident    = ident_ff;
   assign status.mul_done = mul_done_ff;
   assign status.rd_done  = rd_done_ff;

   `ASSERT_ALWAYS(a_rd_not_in_mul, clock, reset, !(active_ff && rd_pend_ff), "read during multiply")
   `ASSERT_IMPLIES(a_done_after_issue, clock, reset, mul_done_ff, !active_ff && !tagc_ff.valid, "multiply done with work in flight")

endmodule

`default_nettype wire

// File: sv/mmpw_ctrl.sv
// controller: square-and-multiply sequencing over the exponent bits and result handoff
`default_nettype none

`include "assert_macros.svh"

module mmpw_ctrl
   import mmpw_pkg::*;
#(
   parameter int EXP_BITS = DEF_EXP_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [EXP_W-1:0] req_exponent,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire status_type       status,
   output cmd_type               cmd
);

   localparam int BW = $clog2(EXP_BITS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_BIT,
      S_SQR,
      S_STEP,
      S_ADJ,
      S_FETCH,
      S_OUT
   } state_type;

   state_type           state_ff;
   logic [EXP_BITS-1:0] exp_ff;
   logic [BW-1:0]       bits_ff;
   logic                rsp_valid_ff, start_mul_ff, use_adj_ff, start_rd_ff;
   logic                slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         exp_ff       <= '0;
         bits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         start_mul_ff <= 1'b0;
         use_adj_ff   <= 1'b0;
         start_rd_ff  <= 1'b0;
      end else begin
         start_mul_ff <= 1'b0;
         start_rd_ff  <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  exp_ff   <= EXP_BITS'(req_exponent);
                  bits_ff  <= BW'(EXP_BITS);
                  state_ff <= S_BIT;
               end
            end
            S_BIT: begin
               if (bits_ff == '0) begin
                  start_rd_ff <= 1'b1;
                  state_ff    <= S_FETCH;
               end else if (!status.ident) begin
                  start_mul_ff <= 1'b1;
                  use_adj_ff   <= 1'b0;
                  state_ff     <= S_SQR;
               end else begin
                  // squaring the identity changes nothing
                  state_ff <= S_STEP;
               end
            end
            S_SQR: begin
               if (status.mul_done) begin
                  state_ff <= S_STEP;
               end
            end
            S_STEP: begin
               if (exp_ff[EXP_BITS-1]) begin
                  start_mul_ff <= 1'b1;
                  use_adj_ff   <= 1'b1;
                  state_ff     <= S_ADJ;
               end else begin
                  exp_ff   <= exp_ff << 1;
                  bits_ff  <= bits_ff - 1'b1;
                  state_ff <= S_BIT;
               end
            end
            S_ADJ: begin
               if (status.mul_done) begin
                  exp_ff   <= exp_ff << 1;
                  bits_ff  <= bits_ff - 1'b1;
                  state_ff <= S_BIT;
               end
            end
            S_FETCH: begin
               if (status.rd_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      cmd.load      = (state_ff == S_IDLE) && req_valid;
      cmd.start_mul = start_mul_ff;
      cmd.use_adj   = use_adj_ff;
      cmd.start_rd  = start_rd_ff;
      cmd.load_rsp  = (state_ff == S_OUT) && slot_free;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_IMPLIES(a_done_while_waiting, clock, reset, status.mul_done, state_ff == S_SQR || state_ff == S_ADJ, "multiply done outside wait state")
   `ASSERT_NEXT(a_load_starts_walk, clock, reset, state_ff == S_IDLE && req_valid, state_ff == S_BIT && bits_ff == BW'(EXP_BITS), "transfer did not start the bit walk")

endmodule

`default_nettype wire

// File: sv/modular_matrix_power_walk_count_core.sv
// one matrix product issues NODES^3 multiply-accumulate steps on the single modular mac pipeline
// an item costs up to 2*EXP_BITS products (leading zero bits skip the squaring);
// items are processed one at a time
// the next item is taken while the previous result waits in the output register
// synchronous active-high reset restores the adjacency rows; matrix memory is not cleared
`default_nettype none

module modular_matrix_power_walk_count_core
   import mmpw_pkg::*;
#(
   parameter int NODES    = DEF_NODES,
   parameter int EXP_BITS = DEF_EXP_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [EXP_W-1:0]     req_exponent,
   input  wire logic [NODE_W-1:0]    req_from_node,
   input  wire logic [NODE_W-1:0]    req_to_node,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [CNT_W-1:0]          rsp_walk_count,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADJ_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   mmpw_ctrl #(
      .EXP_BITS (EXP_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_exponent (req_exponent),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .status       (status),
      .cmd          (cmd)
   );

   mmpw_datapath #(
      .NODES (NODES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_from_node  (req_from_node),
      .req_to_node    (req_to_node),
      .rsp_walk_count (rsp_walk_count),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

`default_nettype wire
